FILE: sv/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Depends on nothing; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FPFA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fpfa assertion failed");
`define FPFA_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("fpfa forbidden condition seen");
`else
`define FPFA_ASSERT(lbl, clk, rst, prop)
`define FPFA_NEVER(lbl, clk, rst, expr)
`endif
`endif

FILE: sv/fpfa_pkg.sv
// Package for the fixed partition first-fit allocator: widths, codes,
// reset sizes, sequencer states and the structs passed between modules.
package fpfa_pkg;

  localparam int NUM_PARTS_DEF  = 4;
  localparam int WAIT_DEPTH_DEF = 8;
  localparam int NUM_REGS       = 4;

  localparam int TAG_W     = 16;
  localparam int ID_W      = 16;
  localparam int SIZE_W    = 9;
  localparam int ADDR_W    = 10;
  localparam int PART_W    = 2;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 4;

  localparam logic [SIZE_W-1:0] PART_SIZE_RESET [NUM_REGS] =
    '{9'd60, 9'd80, 9'd50, 9'd66};

  typedef enum logic [KIND_W-1:0] {
    K_LOADED   = 3'd0,
    K_QUEUED   = 3'd1,
    K_DROPPED  = 3'd2,
    K_RESIDENT = 3'd3,
    K_TERM     = 3'd4,
    K_UNKNOWN  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADMIT_SCAN,
    ST_FIN_SCAN,
    ST_HEAD_CHECK,
    ST_DRAIN_WAIT,
    ST_DRAIN_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [TAG_W-1:0]  tag;
    logic [ID_W-1:0]   id;
    logic [PART_W-1:0] part;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] last_addr;
  } rsp_t;

  typedef struct packed {
    logic              busy;
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
    logic [ID_W-1:0]   id;
  } part_entry_t;

  typedef struct packed {
    logic             load;
    logic             free;
    logic [TAG_W-1:0] tag;
    logic [ID_W-1:0]  id;
  } tbl_op_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
  } wait_entry_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    wait_entry_t data;
  } q_op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

FILE: sv/fpfa_ifs.sv
// Channel interfaces of the allocator: request, result and configuration.
// Each carries valid, ready and its payload word. Depends on fpfa_pkg.
interface fpfa_req_if
  import fpfa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [TAG_W-1:0]  proc_tag;
  logic [SIZE_W-1:0] proc_size;
  logic [ID_W-1:0]   finish_id;

  modport source(output valid, cmd, proc_tag, proc_size, finish_id, input ready);
  modport sink(input valid, cmd, proc_tag, proc_size, finish_id, output ready);
endinterface

interface fpfa_rsp_if
  import fpfa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TAG_W-1:0]  out_tag;
  logic [ID_W-1:0]   out_id;
  logic [PART_W-1:0] out_partition;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] last_addr;
  logic              last;

  modport source(output valid, kind, out_tag, out_id, out_partition, base_addr,
                 last_addr, last, input ready);
  modport sink(input valid, kind, out_tag, out_id, out_partition, base_addr,
               last_addr, last, output ready);
endinterface

interface fpfa_cfg_if
  import fpfa_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: sv/fpfa_wait_queue.sv
// Circular FIFO of waiting admit requests, held in a memory with a
// registered head read. Depends on fpfa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fpfa_wait_queue
  import fpfa_pkg::*;
#(
  parameter int  WAIT_DEPTH = WAIT_DEPTH_DEF,
  localparam int PTR_W      = $clog2(WAIT_DEPTH),
  localparam int CNT_W      = $clog2(WAIT_DEPTH + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  q_op_t       op,
  output wait_entry_t head,
  output q_stat_t     stat
);

  wait_entry_t      mem [WAIT_DEPTH];
  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] head_ptr_inc;
  logic [PTR_W-1:0] tail_ptr;
  logic [PTR_W:0]   tail_sum;
  logic [CNT_W-1:0] count;

  assign tail_sum = {1'b0, head_ptr} + (PTR_W + 1)'(count);
  assign tail_ptr = (tail_sum >= (PTR_W + 1)'(WAIT_DEPTH)) ?
                    PTR_W'(tail_sum - (PTR_W + 1)'(WAIT_DEPTH)) : PTR_W'(tail_sum);
  assign head_ptr_inc = (head_ptr == PTR_W'(WAIT_DEPTH - 1)) ? '0 : head_ptr + 1'b1;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(WAIT_DEPTH));

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[tail_ptr] <= op.data;
    end
    head <= mem[head_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      count    <= '0;
    end else begin
      if (op.pop) begin
        head_ptr <= head_ptr_inc;
      end
      if (op.push && !op.pop) begin
        count <= count + 1'b1;
      end else if (op.pop && !op.push) begin
        count <= count - 1'b1;
      end
    end
  end

  `FPFA_NEVER(a_push_full, clk, rst, op.push && stat.full)
  `FPFA_NEVER(a_pop_empty, clk, rst, op.pop && stat.empty)
  `FPFA_ASSERT(a_count_range, clk, rst, count <= CNT_W'(WAIT_DEPTH))

endmodule

FILE: sv/fpfa_part_table.sv
// Partition table: configured sizes, busy flags, resident tags and ids,
// with one indexed read and one update per cycle. Depends on fpfa_pkg.
module fpfa_part_table
  import fpfa_pkg::*;
#(
  parameter int  NUM_PARTS = NUM_PARTS_DEF,
  localparam int IDX_W     = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  fpfa_cfg_if.sink         cfg,
  input  logic [IDX_W-1:0] idx,
  input  tbl_op_t          op,
  output part_entry_t      ent
);

  logic [NUM_PARTS-1:0] busy;
  logic [SIZE_W-1:0]    size [NUM_PARTS];
  logic [TAG_W-1:0]     tag  [NUM_PARTS];
  logic [ID_W-1:0]      id   [NUM_PARTS];

  assign cfg.ready = 1'b1;

  // Partitions without a register have size zero.
  for (genvar i = 0; i < NUM_PARTS; i++) begin : g_size
    if (i < NUM_REGS) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          size[i] <= PART_SIZE_RESET[i];
        end else if (cfg.valid && cfg.index == CFG_IDX_W'(i)) begin
          size[i] <= cfg.data;
        end
      end
    end else begin : g_zero
      assign size[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (op.load) begin
      busy[idx] <= 1'b1;
    end else if (op.free) begin
      busy[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.load) begin
      tag[idx] <= op.tag;
      id[idx]  <= op.id;
    end
  end

  assign ent.busy = busy[idx];
  assign ent.size = size[idx];
  assign ent.tag  = tag[idx];
  assign ent.id   = id[idx];

endmodule

FILE: sv/fpfa_ctrl.sv
// Sequencer of the allocator: walks the partition table one entry a cycle
// through its single table read port, drains the wait queue and stages results.
// Depends on fpfa_pkg, fpfa_ifs and assert_macros.svh.
`include "assert_macros.svh"

module fpfa_ctrl
  import fpfa_pkg::*;
#(
  parameter int  NUM_PARTS = NUM_PARTS_DEF,
  localparam int IDX_W     = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  fpfa_req_if.sink         req,
  fpfa_rsp_if.source       rsp,
  output logic [IDX_W-1:0] tbl_idx,
  input  part_entry_t      ent,
  output tbl_op_t          tbl_op,
  input  wait_entry_t      head,
  input  q_stat_t          q_stat,
  output q_op_t            q_op
);

  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] base;
  logic              resident;
  logic [TAG_W-1:0]  req_tag;
  logic [SIZE_W-1:0] req_size;
  logic [ID_W-1:0]   req_fid;
  logic [ID_W-1:0]   next_id;
  logic [ID_W-1:0]   id_plus;
  logic [ID_W-1:0]   id_next;
  logic              pend_valid;
  rsp_t              pend;
  logic              out_valid;
  rsp_t              out_q;
  logic              out_last;

  logic fit_req;
  logic fit_head;
  logic id_hit;
  logic res_now;
  logic last_step;
  logic head_fits;
  logic out_free;
  logic can_emit;

  logic emit;
  logic stall;
  rsp_t res;
  logic take;
  logic step;
  logic scan_clr;
  logic flush;
  logic bump;
  logic load_raw;
  logic free_raw;
  logic push_raw;
  logic pop_raw;

  assign fit_req   = !ent.busy && (ent.size >= req_size);
  assign fit_head  = !ent.busy && (ent.size >= head.size);
  assign id_hit    = ent.busy && (ent.id == req_fid);
  assign res_now   = resident || (ent.busy && (ent.tag == req_tag));
  assign last_step = (idx == IDX_W'(NUM_PARTS - 1));
  assign head_fits = !q_stat.empty && (ent.size >= head.size);
  assign out_free  = !out_valid || rsp.ready;
  assign can_emit  = !pend_valid || out_free;

  assign id_plus = next_id + 1'b1;
  assign id_next = (id_plus == '0) ? ID_W'(1) : id_plus;

  always_comb begin
    emit     = 1'b0;
    res      = '0;
    take     = 1'b0;
    step     = 1'b0;
    scan_clr = 1'b0;
    flush    = 1'b0;
    bump     = 1'b0;
    load_raw = 1'b0;
    free_raw = 1'b0;
    push_raw = 1'b0;
    pop_raw  = 1'b0;
    case (state)
      ST_IDLE: begin
        take = req.valid;
      end
      ST_ADMIT_SCAN: begin
        if (fit_req) begin
          emit          = 1'b1;
          res.kind      = K_LOADED;
          res.tag       = req_tag;
          res.id        = next_id;
          res.part      = PART_W'(idx);
          res.base      = base;
          res.last_addr = base + ADDR_W'(req_size) - ADDR_W'(1);
          load_raw      = 1'b1;
          bump          = 1'b1;
        end else if (last_step) begin
          emit    = 1'b1;
          res.tag = req_tag;
          if (res_now) begin
            res.kind = K_RESIDENT;
          end else if (q_stat.full) begin
            res.kind = K_DROPPED;
          end else begin
            res.kind = K_QUEUED;
            push_raw = 1'b1;
          end
        end else begin
          step = 1'b1;
        end
      end
      ST_FIN_SCAN: begin
        if (id_hit) begin
          emit     = 1'b1;
          res.kind = K_TERM;
          res.tag  = ent.tag;
          res.id   = ent.id;
          res.part = PART_W'(idx);
          free_raw = 1'b1;
        end else if (last_step) begin
          emit     = 1'b1;
          res.kind = K_UNKNOWN;
        end else begin
          step = 1'b1;
        end
      end
      ST_HEAD_CHECK: begin
        if (head_fits) begin
          emit          = 1'b1;
          res.kind      = K_LOADED;
          res.tag       = head.tag;
          res.id        = next_id;
          res.part      = PART_W'(idx);
          res.base      = base;
          res.last_addr = base + ADDR_W'(head.size) - ADDR_W'(1);
          load_raw      = 1'b1;
          pop_raw       = 1'b1;
          bump          = 1'b1;
        end
      end
      ST_DRAIN_WAIT: begin
        scan_clr = 1'b1;
      end
      ST_DRAIN_SCAN: begin
        if (fit_head) begin
          emit          = 1'b1;
          res.kind      = K_LOADED;
          res.tag       = head.tag;
          res.id        = next_id;
          res.part      = PART_W'(idx);
          res.base      = base;
          res.last_addr = base + ADDR_W'(head.size) - ADDR_W'(1);
          load_raw      = 1'b1;
          pop_raw       = 1'b1;
          bump          = 1'b1;
        end else if (!last_step) begin
          step = 1'b1;
        end
      end
      ST_DONE: begin
        flush = out_free;
      end
      default: begin
      end
    endcase
    stall = emit && !can_emit;
    if (stall) begin
      load_raw = 1'b0;
      free_raw = 1'b0;
      push_raw = 1'b0;
      pop_raw  = 1'b0;
      bump     = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = req.cmd ? ST_FIN_SCAN : ST_ADMIT_SCAN;
        end
      end
      ST_ADMIT_SCAN: begin
        if ((fit_req || last_step) && !stall) begin
          state_next = ST_DONE;
        end
      end
      ST_FIN_SCAN: begin
        if (id_hit && !stall) begin
          state_next = ST_HEAD_CHECK;
        end else if (last_step && !stall) begin
          state_next = ST_DONE;
        end
      end
      ST_HEAD_CHECK: begin
        if (!stall) begin
          state_next = head_fits ? ST_DRAIN_WAIT : ST_DONE;
        end
      end
      ST_DRAIN_WAIT: begin
        state_next = q_stat.empty ? ST_DONE : ST_DRAIN_SCAN;
      end
      ST_DRAIN_SCAN: begin
        if (fit_head) begin
          if (!stall) begin
            state_next = ST_DRAIN_WAIT;
          end
        end else if (last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      next_id    <= ID_W'(1);
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (bump) begin
        next_id <= id_next;
      end
      if (emit && !stall) begin
        pend_valid <= 1'b1;
      end else if (flush) begin
        pend_valid <= 1'b0;
      end
      if ((emit && !stall && pend_valid) || flush) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_tag  <= req.proc_tag;
      req_size <= req.proc_size;
      req_fid  <= req.finish_id;
      resident <= 1'b0;
    end else if (state == ST_ADMIT_SCAN) begin
      resident <= res_now;
    end
    if (take || scan_clr) begin
      idx  <= '0;
      base <= '0;
    end else if (step) begin
      idx  <= idx + 1'b1;
      base <= base + ADDR_W'(ent.size);
    end
    if (emit && !stall) begin
      pend <= res;
    end
    if ((emit && !stall && pend_valid) || flush) begin
      out_q    <= pend;
      out_last <= flush;
    end
  end

  assign req.ready = (state == ST_IDLE);

  assign tbl_idx     = idx;
  assign tbl_op.load = load_raw;
  assign tbl_op.free = free_raw;
  assign tbl_op.tag  = res.tag;
  assign tbl_op.id   = next_id;

  assign q_op.push      = push_raw;
  assign q_op.pop       = pop_raw;
  assign q_op.data.tag  = req_tag;
  assign q_op.data.size = req_size;

  assign rsp.valid         = out_valid;
  assign rsp.kind          = out_q.kind;
  assign rsp.out_tag       = out_q.tag;
  assign rsp.out_id        = out_q.id;
  assign rsp.out_partition = out_q.part;
  assign rsp.base_addr     = out_q.base;
  assign rsp.last_addr     = out_q.last_addr;
  assign rsp.last          = out_last;

  `FPFA_ASSERT(a_idle_no_pend, clk, rst, req.ready |-> !pend_valid)
  `FPFA_ASSERT(a_id_nonzero, clk, rst, next_id != '0)
  `FPFA_ASSERT(a_load_free_part, clk, rst, tbl_op.load |-> !ent.busy)
  `FPFA_ASSERT(a_flush_has_word, clk, rst, flush |-> pend_valid)

endmodule

FILE: sv/fixed_partition_first_fit_allocator_unit.sv
// Fixed partition first-fit allocator with a FIFO wait queue; one request at a time, no overlap.
// An admit scans the partitions in order from the first and loads the first free one that fits;
// a finish scans for the id, frees its partition and tries the queue head in that partition, and
// each loaded head is followed by a rescan from the first partition for the next queue head.
// Result back-pressure stalls the sequencer. Synchronous reset frees every partition, empties
// the queue, restores the reset sizes and sets the next id to one; no clearing pass.
module fixed_partition_first_fit_allocator_unit
  import fpfa_pkg::*;
#(
  parameter int  NUM_PARTS  = NUM_PARTS_DEF,
  parameter int  WAIT_DEPTH = WAIT_DEPTH_DEF,
  localparam int IDX_W      = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1
) (
  input  logic       clk,
  input  logic       rst,
  fpfa_req_if.sink   req,
  fpfa_rsp_if.source rsp,
  fpfa_cfg_if.sink   cfg
);

  logic [IDX_W-1:0] tbl_idx;
  part_entry_t      ent;
  tbl_op_t          tbl_op;
  wait_entry_t      head;
  q_stat_t          q_stat;
  q_op_t            q_op;

  fpfa_ctrl #(
    .NUM_PARTS(NUM_PARTS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .tbl_idx(tbl_idx),
    .ent    (ent),
    .tbl_op (tbl_op),
    .head   (head),
    .q_stat (q_stat),
    .q_op   (q_op)
  );

  fpfa_part_table #(
    .NUM_PARTS(NUM_PARTS)
  ) u_table (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .idx(tbl_idx),
    .op (tbl_op),
    .ent(ent)
  );

  fpfa_wait_queue #(
    .WAIT_DEPTH(WAIT_DEPTH)
  ) u_queue (
    .clk (clk),
    .rst (rst),
    .op  (q_op),
    .head(head),
    .stat(q_stat)
  );

endmodule
